// ===== rtl/core/crc32_frame_checker_top_assert.svh =====
// assertion macros for the frame checker
`ifndef CRC32_FRAME_CHECKER_TOP_ASSERT_SVH
`define CRC32_FRAME_CHECKER_TOP_ASSERT_SVH
`ifndef SYNTH
`define CFC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame checker assertion failed");
`define CFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame checker assertion failed");
`else
`define CFC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CFC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/cfc_pkg.sv =====
// shared types, constants and the crc byte update of the frame checker
`default_nettype none
package cfc_pkg;
   localparam int MAX_PAYLOAD_BYTES_DEF = 1024;
   localparam int HEADER_BYTES = 8;
   localparam int CRC_BYTES = 4;
   localparam int MIN_FRAME_BYTES = HEADER_BYTES + CRC_BYTES;
   localparam int LEN_W = 16;

   // header byte offsets that complete a field
   localparam int SYNC_LO_POS = 1;
   localparam int SEQ_LO_POS = 3;
   localparam int LEN_LO_POS = 5;
   localparam int TYPE_POS = 6;

   // reflected form of 0x04C11DB7
   localparam logic [31:0] CRC_POLY_REFL = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT_RST = 32'hFFFFFFFF;
   localparam logic [31:0] CRC_FXOR_RST = 32'hFFFFFFFF;
   localparam logic [15:0] SYNC_WORD_RST = 16'h0000;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_IDX_W = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_SYNC_WORD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CRC_INIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CRC_FINAL_XOR = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_TOO_SMALL  = 3'd1,
      ST_SYNC       = 3'd2,
      ST_LENGTH     = 3'd3,
      ST_INCOMPLETE = 3'd4,
      ST_CRC        = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      EMIT_NONE    = 2'd0,
      EMIT_FIXED   = 2'd1,
      EMIT_VERDICT = 2'd2
   } emit_type;

   typedef struct packed {
      logic [7:0]       data;
      logic             eob;
      logic             crc_upd;
      logic             rcv_shift;
      emit_type         emit;
      status_type       status;
      logic [15:0]      seq;
      logic [7:0]       ftype;
      logic [LEN_W-1:0] len;
   } item_type;

   function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h000000, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
      end
      return c;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/core/cfc_front.sv =====
// front part: tracks byte position, parses the header and classifies each item
`default_nettype none
module cfc_front #(
   parameter int MAX_PAYLOAD_BYTES = cfc_pkg::MAX_PAYLOAD_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_end_of_buffer,
   input  logic               q_full,
   input  logic [15:0]        sync_word,
   output logic               push,
   output cfc_pkg::item_type  push_item
);
   import cfc_pkg::*;

   localparam int POS_W = $clog2(MAX_PAYLOAD_BYTES + MIN_FRAME_BYTES + 1);
   localparam int CMP_W = (POS_W > LEN_W) ? POS_W + 1 : LEN_W + 1;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      shift_ff, shift_in;
   logic [15:0]      seq_ff, seq_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       type_ff, type_in;
   status_type       pend_ff, pend_in;
   logic             drop_ff, drop_in;

   logic             in_header;
   logic             in_body;
   logic [POS_W-1:0] pos_nx;
   logic [CMP_W-1:0] pos_nx_ext;
   item_type         item;

   assign push = req_valid && !q_full;
   assign push_item = item;

   always_comb begin
      pos_nx = pos_ff + 1'b1;
      pos_nx_ext = CMP_W'(pos_nx);
      in_header = pos_ff < POS_W'(HEADER_BYTES);
      in_body = !in_header &&
         (CMP_W'(pos_ff) < (CMP_W'(HEADER_BYTES) + CMP_W'(len_ff)));

      pos_in = pos_ff;
      shift_in = shift_ff;
      seq_in = seq_ff;
      len_in = len_ff;
      type_in = type_ff;
      pend_in = pend_ff;
      drop_in = drop_ff;

      item.data = req_rx_byte;
      item.eob = req_end_of_buffer;
      item.crc_upd = 1'b0;
      item.rcv_shift = 1'b0;
      item.emit = EMIT_NONE;
      item.status = ST_OK;

      if (!drop_ff) begin
         item.crc_upd = in_header || in_body;
         item.rcv_shift = !in_header && !in_body;
         pos_in = pos_nx;
         if (in_header) begin
            shift_in = {shift_ff[7:0], req_rx_byte};
            if (pos_ff == POS_W'(SYNC_LO_POS) && shift_in != sync_word) begin
               pend_in = ST_SYNC;
            end else if (pos_ff == POS_W'(SEQ_LO_POS)) begin
               seq_in = shift_in;
            end else if (pos_ff == POS_W'(LEN_LO_POS)) begin
               len_in = shift_in;
               if (pend_ff == ST_OK && shift_in > LEN_W'(MAX_PAYLOAD_BYTES)) begin
                  pend_in = ST_LENGTH;
               end
            end else if (pos_ff == POS_W'(TYPE_POS)) begin
               type_in = req_rx_byte;
            end
         end

         // header errors wait for the twelfth byte
         if (pos_nx == POS_W'(MIN_FRAME_BYTES) && pend_in != ST_OK) begin
            item.emit = EMIT_FIXED;
            item.status = pend_in;
         end else if (pend_in == ST_OK &&
                      pos_nx_ext == CMP_W'(MIN_FRAME_BYTES) + CMP_W'(len_in)) begin
            item.emit = EMIT_VERDICT;
         end else if (req_end_of_buffer) begin
            item.emit = EMIT_FIXED;
            item.status = (pos_nx < POS_W'(MIN_FRAME_BYTES)) ? ST_TOO_SMALL
                                                              : ST_INCOMPLETE;
         end
         if (item.emit != EMIT_NONE && !req_end_of_buffer) begin
            drop_in = 1'b1;
         end
      end

      item.seq = seq_in;
      item.ftype = type_in;
      item.len = len_in;

      // end flag starts a new buffer
      if (req_end_of_buffer) begin
         pos_in = '0;
         shift_in = '0;
         seq_in = '0;
         len_in = '0;
         type_in = '0;
         pend_in = ST_OK;
         drop_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         shift_ff <= '0;
         seq_ff <= '0;
         len_ff <= '0;
         type_ff <= '0;
         pend_ff <= ST_OK;
         drop_ff <= 1'b0;
      end else if (push) begin
         pos_ff <= pos_in;
         shift_ff <= shift_in;
         seq_ff <= seq_in;
         len_ff <= len_in;
         type_ff <= type_in;
         pend_ff <= pend_in;
         drop_ff <= drop_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/cfc_queue.sv =====
// short queue of classified items between front and back
`default_nettype none
module cfc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cfc_pkg::item_type  push_item,
   input  logic               pop,
   output logic               full,
   output logic               head_valid,
   output cfc_pkg::item_type  head_item
);
   import cfc_pkg::*;

   item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/cfc_back.sv =====
// back part: crc register, received crc and the result register
`default_nettype none
module cfc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  cfc_pkg::item_type  head_item,
   input  logic [31:0]        crc_init,
   input  logic [31:0]        crc_final_xor,
   input  logic               rsp_stall,
   output logic               pop,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic [15:0]        rsp_seq_number,
   output logic [7:0]         rsp_frame_type,
   output logic [15:0]        rsp_payload_length
);
   import cfc_pkg::*;

   logic [31:0]      crc_ff, crc_in;
   logic [31:0]      rcv_ff, rcv_in;
   logic             valid_ff, valid_in;
   status_type       status_ff, status_in;
   logic [15:0]      seq_ff, seq_in;
   logic [7:0]       type_ff, type_in;
   logic [LEN_W-1:0] len_ff, len_in;

   logic [31:0]      rcv_shifted;
   logic [31:0]      crc_next;
   status_type       verdict;

   assign pop = head_valid && (!valid_ff || !rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_status = status_ff;
   assign rsp_seq_number = seq_ff;
   assign rsp_frame_type = type_ff;
   assign rsp_payload_length = len_ff;

   always_comb begin
      rcv_shifted = head_item.rcv_shift ? {head_item.data, rcv_ff[31:8]} : rcv_ff;
      crc_next = crc_byte(crc_ff, head_item.data);
      // the completing byte is always a crc byte, so crc_ff is final here
      verdict = ((crc_ff ^ crc_final_xor) == rcv_shifted) ? ST_OK : ST_CRC;

      crc_in = crc_ff;
      rcv_in = rcv_ff;
      valid_in = valid_ff && rsp_stall;
      status_in = status_ff;
      seq_in = seq_ff;
      type_in = type_ff;
      len_in = len_ff;

      if (pop) begin
         if (head_item.eob) begin
            crc_in = crc_init;
            rcv_in = '0;
         end else begin
            if (head_item.crc_upd) begin
               crc_in = crc_next;
            end
            rcv_in = rcv_shifted;
         end

         case (head_item.emit)
            EMIT_FIXED: begin
               valid_in = 1'b1;
               status_in = head_item.status;
               seq_in = '0;
               type_in = '0;
               len_in = '0;
            end
            EMIT_VERDICT: begin
               valid_in = 1'b1;
               status_in = verdict;
               seq_in = (verdict == ST_OK) ? head_item.seq : '0;
               type_in = (verdict == ST_OK) ? head_item.ftype : '0;
               len_in = (verdict == ST_OK) ? head_item.len : '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT_RST;
         rcv_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         crc_ff <= crc_in;
         rcv_ff <= rcv_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      seq_ff <= seq_in;
      type_ff <= type_in;
      len_ff <= len_in;
   end
endmodule
`default_nettype wire

// ===== rtl/core/crc32_frame_checker_top.sv =====
// top level of the frame checker: register port, front, queue and back
`default_nettype none
// Checks byte streams framed as sync(2), sequence(2), length(2), type, flags
// (big-endian header), payload, then a little-endian reflected CRC-32 over
// header and payload. One byte is taken per cycle while req_stall is low; the rate
// is set by the byte-wide CRC update in the back part. A status item is written
// to the result register, behind the queue, once the last byte that decides it
// is taken: at byte twelve for header errors, on the last CRC byte for a complete
// frame, or on the end flag otherwise; later bytes are dropped until the end
// flag. Non-ok results carry zero header fields. Registers: sync_word at 0x0,
// crc_init at 0x4 (loaded into the CRC register when a buffer ends, so it
// applies from the buffer after the next one starts), crc_final_xor at 0x8.
// Write registers only while the block is idle. No startup sweep is needed.
`include "crc32_frame_checker_top_assert.svh"
module crc32_frame_checker_top #(
   parameter int MAX_PAYLOAD_BYTES = cfc_pkg::MAX_PAYLOAD_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_rx_byte,
   input  logic                          req_end_of_buffer,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_status,
   output logic [15:0]                   rsp_seq_number,
   output logic [7:0]                    rsp_frame_type,
   output logic [15:0]                   rsp_payload_length,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [cfc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import cfc_pkg::*;

   logic [15:0]          sync_ff;
   logic [31:0]          crc_init_ff;
   logic [31:0]          fxor_ff;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_idx;

   logic     q_full;
   logic     push;
   item_type push_item;
   logic     pop;
   logic     head_valid;
   item_type head_item;

   assign pready = 1'b1;
   assign csr_idx = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;
   assign req_stall = q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= SYNC_WORD_RST;
         crc_init_ff <= CRC_INIT_RST;
         fxor_ff <= CRC_FXOR_RST;
      end else if (csr_write) begin
         case (csr_idx)
            REG_SYNC_WORD: sync_ff <= pwdata[15:0];
            REG_CRC_INIT: crc_init_ff <= pwdata;
            REG_CRC_FINAL_XOR: fxor_ff <= pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_SYNC_WORD: prdata = {16'h0000, sync_ff};
         REG_CRC_INIT: prdata = crc_init_ff;
         REG_CRC_FINAL_XOR: prdata = fxor_ff;
         default: prdata = '0;
      endcase
   end

   cfc_front #(
      .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_rx_byte(req_rx_byte),
      .req_end_of_buffer(req_end_of_buffer),
      .q_full(q_full),
      .sync_word(sync_ff),
      .push(push),
      .push_item(push_item)
   );

   cfc_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_item(push_item),
      .pop(pop),
      .full(q_full),
      .head_valid(head_valid),
      .head_item(head_item)
   );

   cfc_back u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(head_valid),
      .head_item(head_item),
      .crc_init(crc_init_ff),
      .crc_final_xor(fxor_ff),
      .rsp_stall(rsp_stall),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_seq_number(rsp_seq_number),
      .rsp_frame_type(rsp_frame_type),
      .rsp_payload_length(rsp_payload_length)
   );

   // error results never carry header fields
   `CFC_ASSERT_IMPLY(a_err_fields_zero, clock, reset,
      rsp_valid && rsp_status != ST_OK,
      rsp_seq_number == 16'h0000 && rsp_frame_type == 8'h00 &&
      rsp_payload_length == 16'h0000)
   // an ok frame never has a payload beyond the limit
   `CFC_ASSERT_IMPLY(a_ok_len_limit, clock, reset,
      rsp_valid && rsp_status == ST_OK,
      rsp_payload_length <= 16'(MAX_PAYLOAD_BYTES))
   // the queue only fills behind a held result
   `CFC_ASSERT_IMPLY(a_full_needs_result, clock, reset, req_stall, rsp_valid)
   // a full queue with a stalled result stays full
   `CFC_ASSERT_NEXT(a_full_holds, clock, reset, req_stall && rsp_stall, req_stall)
endmodule
`default_nettype wire
